@@ rtl/pre_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pre_pkg;

    localparam int NUM_FRAMES_DEFAULT = 4;
    localparam int PAGE_BITS          = 16;
    localparam int COUNT_BITS         = 32;
    localparam int FRAME_OUT_BITS     = 2;
    localparam int POLICY_BITS        = 2;

    // Code 3 is unused and falls back to FIFO.
    localparam logic [POLICY_BITS-1:0] POLICY_FIFO  = 2'd0;
    localparam logic [POLICY_BITS-1:0] POLICY_LRU   = 2'd1;
    localparam logic [POLICY_BITS-1:0] POLICY_CLOCK = 2'd2;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page_number;
    } t_page_req;

    typedef struct packed {
        logic                      hit;
        logic [FRAME_OUT_BITS-1:0] frame_index;
        logic                      evicted_valid;
        logic [PAGE_BITS-1:0]      evicted_page;
        logic [COUNT_BITS-1:0]     fault_total;
        logic [COUNT_BITS-1:0]     hit_total;
    } t_result;

    typedef struct packed {
        logic [POLICY_BITS-1:0] policy_mode;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic sweep;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_sweep;
        logic sweep_found;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/pre_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pre_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pre_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pre_datapath #(
    parameter int NUM_FRAMES = pre_pkg::NUM_FRAMES_DEFAULT
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [pre_pkg::POLICY_BITS-1:0]   i_cfg_policy,
    input  wire  [pre_pkg::PAGE_BITS-1:0]     i_page_number,
    input  wire  pre_pkg::t_dp_cmd            i_cmd,
    output pre_pkg::t_dp_status               o_status,
    output pre_pkg::t_result                  o_result
);

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int FILL_W = $clog2(NUM_FRAMES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_FRAMES - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(NUM_FRAMES);
    localparam logic [pre_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [pre_pkg::POLICY_BITS-1:0] r_policy;
    logic [pre_pkg::PAGE_BITS-1:0]   r_page;
    logic [pre_pkg::PAGE_BITS-1:0]   r_frame_page [NUM_FRAMES];
    logic [NUM_FRAMES-1:0]           r_frame_valid;
    logic [FILL_W-1:0]               r_fill;
    logic [IDX_W-1:0]                r_fifo_ptr;
    logic [IDX_W-1:0]                r_hand;
    logic [IDX_W-1:0]                r_rank [NUM_FRAMES];
    logic [NUM_FRAMES-1:0]           r_ref;
    logic [pre_pkg::COUNT_BITS-1:0]  r_fault_cnt;
    logic [pre_pkg::COUNT_BITS-1:0]  r_hit_cnt;
    logic                            r_hit;
    logic [IDX_W-1:0]                r_frame;
    pre_pkg::t_result                r_out;

    logic                            full;
    logic                            match_any;
    logic [IDX_W-1:0]                match_idx;
    logic [IDX_W-1:0]                lru_idx;
    logic [IDX_W-1:0]                n_frame;
    logic                            replace;
    logic                            use_lru;
    logic                            use_clock;
    logic [pre_pkg::COUNT_BITS-1:0]  n_fault_cnt;
    logic [pre_pkg::COUNT_BITS-1:0]  n_hit_cnt;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign full      = (r_fill == FULL_FILL);
    assign use_lru   = (r_policy == pre_pkg::POLICY_LRU);
    assign use_clock = (r_policy == pre_pkg::POLICY_CLOCK);
    assign replace   = !r_hit && full;

    // Lowest matching frame wins; resident pages are distinct anyway.
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (r_frame_valid[i] && (r_frame_page[i] == r_page)) begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // With a full table the ranks form a permutation, so the least recently
    // used frame is the one holding the highest rank.
    always_comb begin
        lru_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (r_rank[i] == LAST_IDX) begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        priority if (match_any) begin
            n_frame = match_idx;
        end else if (!full) begin
            n_frame = r_fill[IDX_W-1:0];
        end else if (use_lru) begin
            n_frame = lru_idx;
        end else if (use_clock) begin
            n_frame = r_hand;
        end else begin
            n_frame = r_fifo_ptr;
        end
    end

    assign o_status.need_sweep  = !match_any && full && use_clock;
    assign o_status.sweep_found = !r_ref[r_frame];

    assign n_fault_cnt = (!r_hit && (r_fault_cnt != COUNT_MAX)) ? r_fault_cnt + 1'b1
                                                                 : r_fault_cnt;
    assign n_hit_cnt   = (r_hit && (r_hit_cnt != COUNT_MAX)) ? r_hit_cnt + 1'b1 : r_hit_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= pre_pkg::POLICY_FIFO;
            r_frame_valid <= '0;
            r_fill        <= '0;
            r_fifo_ptr    <= '0;
            r_hand        <= '0;
            r_ref         <= '1;
            r_fault_cnt   <= '0;
            r_hit_cnt     <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_policy;
            end
            if (i_cmd.sweep && r_ref[r_frame]) begin
                r_ref[r_frame] <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (!r_hit) begin
                    r_frame_valid[r_frame] <= 1'b1;
                    if (!full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                // Frames more recent than the touched one age by one step.
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (r_frame_valid[i] && (IDX_W'(i) != r_frame)
                            && ((!r_hit && !full) || (r_rank[i] < r_rank[r_frame]))) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rank[r_frame] <= '0;
                r_ref[r_frame]  <= 1'b1;
                if (replace && use_clock) begin
                    r_hand <= next_idx(r_frame);
                end
                if (replace && !use_clock && !use_lru) begin
                    r_fifo_ptr <= next_idx(r_frame);
                end
                r_fault_cnt <= n_fault_cnt;
                r_hit_cnt   <= n_hit_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= i_page_number;
        end
        if (i_cmd.lookup) begin
            r_hit   <= match_any;
            r_frame <= n_frame;
        end
        if (i_cmd.sweep && r_ref[r_frame]) begin
            r_frame <= next_idx(r_frame);
        end
        if (i_cmd.commit) begin
            if (!r_hit) begin
                r_frame_page[r_frame] <= r_page;
            end
            r_out.hit           <= r_hit;
            r_out.frame_index   <= pre_pkg::FRAME_OUT_BITS'(r_frame);
            r_out.evicted_valid <= replace;
            r_out.evicted_page  <= replace ? r_frame_page[r_frame] : '0;
            r_out.fault_total   <= n_fault_cnt;
            r_out.hit_total     <= n_hit_cnt;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

@@ rtl/pre_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pre_controller (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_out_ready,
    input  wire  pre_pkg::t_dp_status i_status,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output pre_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_status.need_sweep ? S_SWEEP : S_COMMIT;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_found) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // The result register may be refilled in the cycle it drains.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/page_replacement_engine.sv @@
// An accepted reference passes the lookup and commit steps of the controller on a hit or a
// FIFO, LRU or fill fault; a clock fault adds a hand sweep between them. A new reference is
// accepted only in idle, after the last one has committed, and the commit waits while the
// output holds an untaken result; one result may wait in the output.
// Reset (synchronous, active low) empties the frame table, zeroes ranks, pointers and
// totals, sets all reference bits and selects FIFO.
`timescale 1ns / 1ps
`default_nettype none

module page_replacement_engine #(
    parameter int NUM_FRAMES = pre_pkg::NUM_FRAMES_DEFAULT
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pre_stream_if.sink   i_cfg,
    pre_stream_if.sink   i_page,
    pre_stream_if.source o_result
);

    pre_pkg::t_dp_cmd    cmd;
    pre_pkg::t_dp_status status;
    pre_pkg::t_cfg       cfg_data;
    pre_pkg::t_page_req  page_data;
    pre_pkg::t_result    result_data;
    logic                in_ready;
    logic                out_valid;

    assign cfg_data  = i_cfg.data;
    assign page_data = i_page.data;

    assign i_cfg.ready   = 1'b1;
    assign i_page.ready  = in_ready;
    assign o_result.valid = out_valid;
    assign o_result.data  = result_data;

    pre_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_page.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    pre_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_policy  (cfg_data.policy_mode),
        .i_page_number (page_data.page_number),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_result      (result_data)
    );

endmodule

`default_nettype wire
